// ----- rtl/core/pci_pkg.sv -----
// pci_pkg: word types, register offsets and state codes for the
// periodic curve interpolator. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pci_pkg;

  localparam int VecN = 9;
  localparam int VecW = 32;
  localparam int AngW = 16;
  localparam int PaddrW = 3;
  localparam logic [PaddrW-1:0] REG_KNOTS_IN_USE = 3'd0;
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_QUERY = 1'b1;
  localparam logic [AngW:0] FULL_TURN = 17'h10000;
  localparam logic [8:0] KNOTS_RESET = 9'd2;

  typedef struct packed {
    logic               kind;
    logic [7:0]         knot_index;
    logic signed [31:0] angle;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tan_x;
    logic signed [31:0] tan_y;
    logic signed [31:0] tan_z;
    logic signed [31:0] nrm_x;
    logic signed [31:0] nrm_y;
    logic signed [31:0] nrm_z;
  } req_word_t;

  typedef struct packed {
    logic               status;
    logic [7:0]         lower_knot;
    logic [16:0]        weight_right;
    logic signed [31:0] out_pos_x;
    logic signed [31:0] out_pos_y;
    logic signed [31:0] out_pos_z;
    logic signed [31:0] out_tan_x;
    logic signed [31:0] out_tan_y;
    logic signed [31:0] out_tan_z;
    logic signed [31:0] out_nrm_x;
    logic signed [31:0] out_nrm_y;
    logic signed [31:0] out_nrm_z;
  } rsp_word_t;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_SCAN = 9'b000000010,
    S_DIV  = 9'b000000100,
    S_RDA  = 9'b000001000,
    S_RDB  = 9'b000010000,
    S_RDC  = 9'b000100000,
    S_MUL  = 9'b001000000,
    S_ADD  = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

endpackage
`default_nettype wire

// ----- rtl/core/periodic_curve_interpolator.sv -----
// Periodic curve interpolator: knot store, linear interval search, serial
// divider and a shared multiply/add unit for the nine blended components.
// Depends on pci_pkg.
//
// Usage: one request channel (req_valid/req_ready, word req) and one
// response channel (rsp_valid/rsp_ready, word rsp); one response word per
// request word. A load (kind 0) writes one knot and goes straight to the
// final step to answer. A query (kind 1) searches the knot angles: the
// search reads one knot angle a cycle from the angle memory, up to the
// clamped knot count; on a hit a 16-step restoring divider forms the
// weight, two reads of the vector memory fetch both knots and one shared
// 33x17 multiplier with an adder blends each component in a multiply step
// and an add step.
// One word is in work at a time; req_ready is high only while idle.
// A finished response sits in the output register until taken; a stalled
// receiver holds the block in its final step, and the next request may
// already be accepted while the previous response waits.
// Reset clears control state and sets knots_in_use to 2; knot memories
// are not cleared and must be loaded before use.
`timescale 1ns / 1ps
`default_nettype none
module periodic_curve_interpolator
  import pci_pkg::*;
#(
  parameter int MAX_KNOTS = 256
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              req_valid,
  output logic                   req_ready,
  input  wire req_word_t         req,
  output logic                   rsp_valid,
  input  wire logic              rsp_ready,
  output rsp_word_t              rsp,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready
);

  localparam int AW = (MAX_KNOTS > 2) ? $clog2(MAX_KNOTS) : 1;
  localparam int CW = $clog2(MAX_KNOTS + 1);
  localparam int RowW = VecN * VecW;

  state_t state;
  logic [8:0] knots_in_use;

  logic [AngW-1:0] ang_mem [MAX_KNOTS];
  logic [RowW-1:0] vec_mem [MAX_KNOTS];
  logic [AngW-1:0] ang_q;
  logic [RowW-1:0] vec_q;
  logic [AW-1:0]   ang_addr, vec_addr;

  logic [CW-1:0]   n_knots, scan_cnt;
  logic            rd_valid;
  logic [AW-1:0]   rd_idx;
  logic [AngW-1:0] prev_ang, s_ang, pre_ang;
  logic [AngW:0]   nxt_ang, den;
  logic            found, wrap, load_ack;
  logic [AW-1:0]   id, hi_idx;
  logic [7:0]      load_idx;
  logic [4:0]      div_cnt;
  logic [AngW+1:0] rem, rem_sh;
  logic [AngW-1:0] quo;
  logic [RowW-1:0] lo_row, hi_row;
  logic [3:0]      comp;
  logic signed [49:0] prod, prod_rnd;
  logic signed [32:0] diff;
  logic [VecW-1:0] res [VecN];
  logic [VecW-1:0] lo_c, hi_c;
  logic hit, last_hit, req_fire, wr_ok;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_KNOTS_IN_USE[2]) ? {23'd0, knots_in_use} : 32'd0;
  assign req_ready = (state == S_IDLE);
  assign req_fire = req_valid && req_ready;
  assign wr_ok = req_fire && req.kind == KIND_LOAD && 32'(req.knot_index) < MAX_KNOTS;

  always_comb begin
    if (32'(knots_in_use) > MAX_KNOTS) begin
      n_knots = CW'(MAX_KNOTS);
    end else if (knots_in_use < 9'd2) begin
      n_knots = CW'(2);
    end else begin
      n_knots = CW'(knots_in_use);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      knots_in_use <= KNOTS_RESET;
    end else if (psel && penable && pwrite && paddr[2] == REG_KNOTS_IN_USE[2]) begin
      knots_in_use <= pwdata[8:0];
    end
  end

  assign ang_addr = AW'(scan_cnt);
  assign vec_addr = (state == S_RDB) ? hi_idx : id;
  assign hi_idx = wrap ? '0 : AW'(id + 1'b1);

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      ang_mem[AW'(req.knot_index)] <= req.angle[AngW-1:0];
      vec_mem[AW'(req.knot_index)] <= {req.nrm_z, req.nrm_y, req.nrm_x,
                                       req.tan_z, req.tan_y, req.tan_x,
                                       req.pos_z, req.pos_y, req.pos_x};
    end
    ang_q <= ang_mem[ang_addr];
    vec_q <= vec_mem[vec_addr];
  end

  assign hit = (rd_idx != '0) && (prev_ang <= s_ang) && (s_ang < ang_q);
  assign last_hit = (s_ang >= ang_q);
  assign rem_sh = {rem[AngW:0], 1'b0};
  assign lo_c = lo_row[comp*VecW +: VecW];
  assign hi_c = hi_row[comp*VecW +: VecW];
  assign diff = $signed({hi_c[VecW-1], hi_c}) - $signed({lo_c[VecW-1], lo_c});
  assign prod_rnd = (prod + 50'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      rsp_valid <= 1'b0;
      rd_valid <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready && state != S_DONE) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_fire) begin
            s_ang <= req.angle[AngW-1:0];
            load_idx <= req.knot_index;
            load_ack <= (req.kind == KIND_LOAD);
            found <= 1'b0;
            wrap <= 1'b0;
            scan_cnt <= '0;
            rd_valid <= 1'b0;
            quo <= '0;
            for (int k = 0; k < VecN; k++) begin
              res[k] <= '0;
            end
            state <= (req.kind == KIND_LOAD) ? S_DONE : S_SCAN;
          end
        end
        S_SCAN: begin
          if (scan_cnt < n_knots) begin
            rd_valid <= 1'b1;
            rd_idx <= AW'(scan_cnt);
            scan_cnt <= scan_cnt + 1'b1;
          end else begin
            rd_valid <= 1'b0;
          end
          if (rd_valid) begin
            prev_ang <= ang_q;
            if (hit && !found) begin
              found <= 1'b1;
              id <= rd_idx - 1'b1;
              pre_ang <= prev_ang;
              nxt_ang <= {1'b0, ang_q};
            end
            if (CW'(rd_idx) == n_knots - 1'b1) begin
              div_cnt <= '0;
              if (last_hit) begin
                found <= 1'b1;
                wrap <= 1'b1;
                id <= rd_idx;
                pre_ang <= ang_q;
                nxt_ang <= FULL_TURN;
                state <= S_DIV;
              end else if (found || hit) begin
                state <= S_DIV;
              end else begin
                found <= 1'b0;
                id <= '0;
                state <= S_DONE;
              end
            end
          end
        end
        S_DIV: begin
          if (div_cnt == 5'd0) begin
            rem <= {2'b00, s_ang - pre_ang};
            den <= nxt_ang - {1'b0, pre_ang};
          end else if (rem_sh >= {1'b0, den}) begin
            rem <= rem_sh - {1'b0, den};
            quo <= {quo[AngW-2:0], 1'b1};
          end else begin
            rem <= rem_sh;
            quo <= {quo[AngW-2:0], 1'b0};
          end
          div_cnt <= div_cnt + 1'b1;
          if (div_cnt == 5'd16) begin
            state <= S_RDA;
          end
        end
        S_RDA: state <= S_RDB;
        S_RDB: begin
          lo_row <= vec_q;
          state <= S_RDC;
        end
        S_RDC: begin
          hi_row <= vec_q;
          comp <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          prod <= diff * $signed({1'b0, quo});
          state <= S_ADD;
        end
        S_ADD: begin
          res[comp] <= lo_c + prod_rnd[VecW-1:0];
          comp <= comp + 1'b1;
          state <= (comp == 4'(VecN - 1)) ? S_DONE : S_MUL;
        end
        S_DONE: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid <= 1'b1;
            rsp.status <= !load_ack && !found;
            rsp.lower_knot <= load_ack ? load_idx : 8'(id);
            rsp.weight_right <= {1'b0, quo};
            rsp.out_pos_x <= res[0];
            rsp.out_pos_y <= res[1];
            rsp.out_pos_z <= res[2];
            rsp.out_tan_x <= res[3];
            rsp.out_tan_y <= res[4];
            rsp.out_tan_z <= res[5];
            rsp.out_nrm_x <= res[6];
            rsp.out_nrm_y <= res[7];
            rsp.out_nrm_z <= res[8];
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_den_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && div_cnt != 5'd0) |-> den != '0)
    else $error("divider started with zero interval");
  a_weight_range: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !rsp.weight_right[16])
    else $error("weight out of range");
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp.status) |-> (rsp.lower_knot == 8'd0 && rsp.out_pos_x == 0
      && rsp.weight_right == 17'd0))
    else $error("miss response not cleared");
`endif

endmodule
`default_nettype wire
